### src/unicode_simple_case_fold_unit_macros.svh
// Assertion macros used by the case fold unit's checker.
`ifndef UNICODE_SIMPLE_CASE_FOLD_UNIT_MACROS_SVH
`define UNICODE_SIMPLE_CASE_FOLD_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define USCF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("case fold check failed");

// Next-cycle implication, disabled while reset is asserted.
`define USCF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("case fold check failed");

`endif

### src/uscf_pkg.sv
// Types, codes and constants of the simple case fold unit.
`default_nettype none

package uscf_pkg;

	// Field widths.
	localparam int unsigned CP_W       = 21;
	localparam int unsigned WORD_W     = 46;
	localparam int unsigned IDX_W      = 10;
	localparam int unsigned TOTAL_W    = 11;
	localparam int unsigned DELTA_W    = 17;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 21;

	// Default table depth.
	localparam int unsigned DEFAULT_RUN_DEPTH = 1024;

	// Codepoint limits.
	localparam logic [CP_W-1:0] CP_TOP      = 21'h10FFFF;
	localparam logic [CP_W-1:0] ASCII_LIMIT = 21'd128;
	localparam logic [CP_W-1:0] UPPER_A     = 21'h41;
	localparam logic [CP_W-1:0] UPPER_Z     = 21'h5A;
	localparam logic [CP_W-1:0] CASE_STEP   = 21'd32;

	// Reset value of the delta bias.
	localparam logic [DELTA_W-1:0] DELTA_OFFSET_RST = 17'h10000;

	// Opcodes.
	localparam logic [1:0] OP_QUERY      = 2'd0;
	localparam logic [1:0] OP_FOLD_LOAD  = 2'd1;
	localparam logic [1:0] OP_LOWER_LOAD = 2'd2;

	// Answer sources.
	localparam logic [1:0] BY_ASCII     = 2'd0;
	localparam logic [1:0] BY_FOLD      = 2'd1;
	localparam logic [1:0] BY_LOWER     = 2'd2;
	localparam logic [1:0] BY_UNCHANGED = 2'd3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_FOLD_TOTAL  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LOWER_TOTAL = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FOLD_LOW    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FOLD_HIGH   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_LOWER_LOW   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_LOWER_HIGH  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_DELTA_OFF   = 3'd6;

	// One command.
	typedef struct packed {
		logic [1:0]        opcode;
		logic [IDX_W-1:0]  entry_index;
		logic [WORD_W-1:0] run_word;
		logic [CP_W-1:0]   codepoint;
	} req_t;

	// One result.
	typedef struct packed {
		logic [CP_W-1:0] folded;
		logic [1:0]      answered_by;
		logic            range_error;
	} rsp_t;

endpackage

`default_nettype wire

### src/unicode_simple_case_fold_unit.sv
// Top level of the simple Unicode case fold unit with its two run tables.
`default_nettype none

// A command is taken when start is high and busy is low. Run word loads write
// one table slot in the cycle they are taken and give no result. A query with
// an ASCII codepoint gives its result in the cycle after it is taken. Any other
// query binary-searches the fold table and, on a miss, the lowercase table:
// each table has a setup step, then per probe a memory read and then a
// compare, with at most log2(RUN_DEPTH)+1 probes; a hit then passes through
// a delta sum step. The result is shown for exactly one cycle with done high
// and cannot be held off by the receiver; busy stays high through that cycle.
// Configuration writes are always ready and must only be made while the unit
// is idle. The tables need no clearing after reset.
module unicode_simple_case_fold_unit #(
	parameter int unsigned RUN_DEPTH = uscf_pkg::DEFAULT_RUN_DEPTH
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               start,
	output logic                              busy,
	input  uscf_pkg::req_t                    req,
	output logic                              done,
	output uscf_pkg::rsp_t                    rsp,
	input  wire                               cfg_valid,
	output logic                              cfg_ready,
	input  wire  [uscf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire  [uscf_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int unsigned IW = $clog2(RUN_DEPTH);
	localparam int unsigned CW = $clog2(RUN_DEPTH + 1);
	localparam int unsigned CPW = uscf_pkg::CP_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SETUP,
		S_PROBE,
		S_CMP,
		S_SUM
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [uscf_pkg::TOTAL_W-1:0] fold_total_q;
	logic [uscf_pkg::TOTAL_W-1:0] lower_total_q;
	logic [CPW-1:0]               fold_low_q;
	logic [CPW-1:0]               fold_high_q;
	logic [CPW-1:0]               lower_low_q;
	logic [CPW-1:0]               lower_high_q;
	logic [uscf_pkg::DELTA_W-1:0] delta_off_q;

	// Search registers.
	logic [CPW-1:0]               cp_q;
	logic                         tbl_q;
	logic [CW-1:0]                lo_q;
	logic [CW-1:0]                hi_q;
	logic [CW-1:0]                mid_q;
	logic signed [uscf_pkg::DELTA_W:0] delta_q;
	logic [1:0]                   by_q;
	logic                         done_q;
	uscf_pkg::rsp_t               rsp_q;

	// Run tables and their read data.
	logic [uscf_pkg::WORD_W-1:0] fold_mem [RUN_DEPTH];
	logic [uscf_pkg::WORD_W-1:0] lower_mem [RUN_DEPTH];
	logic [uscf_pkg::WORD_W-1:0] fold_rd_q;
	logic [uscf_pkg::WORD_W-1:0] lower_rd_q;

	logic accept;
	logic load_ok;
	logic [IW-1:0] wr_addr;

	assign busy      = (state_q != S_IDLE) || done_q;
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign rsp       = rsp_q;

	assign load_ok = 32'(req.entry_index) < RUN_DEPTH;
	assign wr_addr = IW'(req.entry_index);

	// Midpoint of the current search interval.
	logic [CW-1:0] mid;
	logic          probe_live;
	assign mid        = lo_q + ((hi_q - lo_q) >> 1);
	assign probe_live = (state_q == S_PROBE) && (lo_q < hi_q);

	// Fold run table: load port and search read port.
	always_ff @(posedge clk) begin
		if (accept && req.opcode == uscf_pkg::OP_FOLD_LOAD && load_ok) begin
			fold_mem[wr_addr] <= req.run_word;
		end
		if (probe_live) begin
			fold_rd_q <= fold_mem[IW'(mid)];
		end
	end

	// Lowercase run table: load port and search read port.
	always_ff @(posedge clk) begin
		if (accept && req.opcode == uscf_pkg::OP_LOWER_LOAD && load_ok) begin
			lower_mem[wr_addr] <= req.run_word;
		end
		if (probe_live) begin
			lower_rd_q <= lower_mem[IW'(mid)];
		end
	end

	// Setup of the current table: window test and clamped run total.
	logic [uscf_pkg::TOTAL_W-1:0] cur_total;
	logic [CW-1:0]                cur_hi;
	logic                         in_window;
	always_comb begin
		cur_total = tbl_q ? lower_total_q : fold_total_q;
		if (32'(cur_total) > RUN_DEPTH) begin
			cur_hi = CW'(RUN_DEPTH);
		end else begin
			cur_hi = CW'(cur_total);
		end
		if (tbl_q) begin
			in_window = (cp_q >= lower_low_q) && (cp_q <= lower_high_q);
		end else begin
			in_window = (cp_q >= fold_low_q) && (cp_q <= fold_high_q);
		end
	end

	// Run word decode and compare against the held codepoint.
	logic [uscf_pkg::WORD_W-1:0]  rd_word;
	logic [CPW-1:0]               w_start;
	logic [6:0]                   w_count;
	logic                         w_stride2;
	logic [uscf_pkg::DELTA_W-1:0] w_stored;
	logic [7:0]                   w_span;
	logic [CPW:0]                 w_last;
	logic                         cp_below;
	logic                         cp_beyond;
	logic                         stride_off;
	always_comb begin
		rd_word    = tbl_q ? lower_rd_q : fold_rd_q;
		w_start    = rd_word[20:0];
		w_count    = rd_word[27:21];
		w_stride2  = rd_word[28];
		w_stored   = rd_word[45:29];
		w_span     = {1'b0, w_count - 7'd1} << w_stride2;
		w_last     = {1'b0, w_start} + (CPW + 1)'(w_span);
		cp_below   = cp_q < w_start;
		cp_beyond  = {1'b0, cp_q} > w_last;
		stride_off = w_stride2 && (cp_q[0] ^ w_start[0]);
	end

	// Sum of codepoint and delta, clamped in the sum state.
	logic signed [CPW+1:0] sum;
	assign sum = $signed({2'b00, cp_q}) + (CPW + 2)'(delta_q);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fold_total_q  <= '0;
			lower_total_q <= '0;
			fold_low_q    <= '0;
			fold_high_q   <= '0;
			lower_low_q   <= '0;
			lower_high_q  <= '0;
			delta_off_q   <= uscf_pkg::DELTA_OFFSET_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				uscf_pkg::CFG_FOLD_TOTAL:  fold_total_q  <= cfg_data[uscf_pkg::TOTAL_W-1:0];
				uscf_pkg::CFG_LOWER_TOTAL: lower_total_q <= cfg_data[uscf_pkg::TOTAL_W-1:0];
				uscf_pkg::CFG_FOLD_LOW:    fold_low_q    <= cfg_data;
				uscf_pkg::CFG_FOLD_HIGH:   fold_high_q   <= cfg_data;
				uscf_pkg::CFG_LOWER_LOW:   lower_low_q   <= cfg_data;
				uscf_pkg::CFG_LOWER_HIGH:  lower_high_q  <= cfg_data;
				uscf_pkg::CFG_DELTA_OFF:   delta_off_q   <= cfg_data[uscf_pkg::DELTA_W-1:0];
				default: ;
			endcase
		end
	end

	// Search sequencer with registered result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
			tbl_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept && req.opcode == uscf_pkg::OP_QUERY) begin
						cp_q <= req.codepoint;
						if (req.codepoint < uscf_pkg::ASCII_LIMIT) begin
							rsp_q.answered_by <= uscf_pkg::BY_ASCII;
							rsp_q.range_error <= 1'b0;
							if (req.codepoint >= uscf_pkg::UPPER_A &&
							    req.codepoint <= uscf_pkg::UPPER_Z) begin
								rsp_q.folded <= req.codepoint + uscf_pkg::CASE_STEP;
							end else begin
								rsp_q.folded <= req.codepoint;
							end
							done_q <= 1'b1;
						end else begin
							tbl_q   <= 1'b0;
							state_q <= S_SETUP;
						end
					end
				end
				S_SETUP: begin
					lo_q    <= '0;
					hi_q    <= in_window ? cur_hi : '0;
					state_q <= S_PROBE;
				end
				S_PROBE: begin
					if (lo_q < hi_q) begin
						mid_q   <= mid;
						state_q <= S_CMP;
					end else if (!tbl_q) begin
						tbl_q   <= 1'b1;
						state_q <= S_SETUP;
					end else begin
						rsp_q.folded      <= cp_q;
						rsp_q.answered_by <= uscf_pkg::BY_UNCHANGED;
						rsp_q.range_error <= 1'b0;
						done_q            <= 1'b1;
						state_q           <= S_IDLE;
					end
				end
				S_CMP: begin
					if (cp_below) begin
						hi_q    <= mid_q;
						state_q <= S_PROBE;
					end else if (w_count == 7'd0 || cp_beyond) begin
						lo_q    <= mid_q + CW'(1);
						state_q <= S_PROBE;
					end else if (stride_off) begin
						// The run spans the codepoint but skips it: this table misses.
						if (!tbl_q) begin
							tbl_q   <= 1'b1;
							state_q <= S_SETUP;
						end else begin
							rsp_q.folded      <= cp_q;
							rsp_q.answered_by <= uscf_pkg::BY_UNCHANGED;
							rsp_q.range_error <= 1'b0;
							done_q            <= 1'b1;
							state_q           <= S_IDLE;
						end
					end else begin
						delta_q <= $signed({1'b0, w_stored}) - $signed({1'b0, delta_off_q});
						by_q    <= tbl_q ? uscf_pkg::BY_LOWER : uscf_pkg::BY_FOLD;
						state_q <= S_SUM;
					end
				end
				S_SUM: begin
					rsp_q.answered_by <= by_q;
					if (sum < 0) begin
						rsp_q.folded      <= '0;
						rsp_q.range_error <= 1'b1;
					end else if (sum > $signed({2'b00, uscf_pkg::CP_TOP})) begin
						rsp_q.folded      <= uscf_pkg::CP_TOP;
						rsp_q.range_error <= 1'b1;
					end else begin
						rsp_q.folded      <= sum[CPW-1:0];
						rsp_q.range_error <= 1'b0;
					end
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

### src/uscf_checker.sv
// Port-level checker of the simple case fold unit and its bind statement.
`default_nettype none

`include "unicode_simple_case_fold_unit_macros.svh"

module uscf_checker (
	input wire            clk,
	input wire            arst_n,
	input wire            start,
	input wire            busy,
	input uscf_pkg::req_t req,
	input wire            done,
	input uscf_pkg::rsp_t rsp
);

	// A result is a single-cycle strobe, and the unit stays busy while it shows.
	`USCF_ASSERT_NEXT(a_done_pulse, clk, arst_n, done, !done)
	`USCF_ASSERT_NOW(a_done_busy, clk, arst_n, done, busy)

	// An accepted query keeps the unit busy until its result transaction.
	`USCF_ASSERT_NEXT(a_query_busy, clk, arst_n,
		start && !busy && req.opcode == uscf_pkg::OP_QUERY, busy)

	// Only a table hit can leave the codepoint range.
	`USCF_ASSERT_NOW(a_err_source, clk, arst_n, done && rsp.range_error,
		rsp.answered_by == uscf_pkg::BY_FOLD || rsp.answered_by == uscf_pkg::BY_LOWER)

	// The ASCII rule never leaves ASCII.
	`USCF_ASSERT_NOW(a_ascii_stays, clk, arst_n,
		done && rsp.answered_by == uscf_pkg::BY_ASCII, rsp.folded < uscf_pkg::ASCII_LIMIT)

endmodule

bind unicode_simple_case_fold_unit uscf_checker u_uscf_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.req    (req),
	.done   (done),
	.rsp    (rsp)
);

`default_nettype wire
